// ===== rtl/mbsl_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsl_pkg - shared types and constants for the slot lock manager
// Operation and status codes, payload widths, controller state and commands.
// ----------------------------------------------------------------------------
`default_nettype none

package mbsl_pkg;

  // default sizing
  localparam int SLOT_COUNT_DEF  = 8;
  localparam int ENTRY_COUNT_DEF = 4;
  localparam int MAX_READERS_DEF = 15;

  // fixed payload widths
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 3;
  localparam int STATUS_W = 2;
  localparam int GSLOT_W  = 3;
  localparam int RENTRY_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RD_ACQ = 2'd0,
    OP_RD_REL = 2'd1,
    OP_WR_ACQ = 2'd2,
    OP_WR_REL = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NONE_FREE = 2'd2,
    ST_NOT_HELD  = 2'd3
  } status_t;

  typedef enum logic {
    CTL_EMPTY = 1'b0,
    CTL_FULL  = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic load;
  } mbsl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/mbsl_if.sv =====
// ----------------------------------------------------------------------------
// mbsl_if - request and result channels of the slot lock manager
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbsl_req_if;
  import mbsl_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output operation, output handle, input ready);
  modport sink   (input valid, input operation, input handle, output ready);
endinterface

interface mbsl_rsp_if;
  import mbsl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [GSLOT_W-1:0]  granted_slot;
  logic [RENTRY_W-1:0] reader_entry;

  modport source (output valid, output status, output granted_slot,
                  output reader_entry, input ready);
  modport sink   (input valid, input status, input granted_slot,
                  input reader_entry, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbsl_ctrl - handshake controller
// Tracks whether the result register holds a word and issues the load command.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mbsl_pkg::mbsl_cmd_t     cmd
);
  import mbsl_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    case (state_r)
      CTL_EMPTY: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = CTL_FULL;
        end
      end
      CTL_FULL: begin
        out_valid = 1'b1;
        // a word leaving frees the register for the next request
        in_ready  = out_ready;
        cmd.load  = in_valid && out_ready;
        if (out_ready && !in_valid) begin
          state_nxt = CTL_EMPTY;
        end
      end
      default: begin
        state_nxt = CTL_EMPTY;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mbsl_datapath.sv =====
// ----------------------------------------------------------------------------
// mbsl_datapath - lock state and result register
// Holds latest slot, writer mask and reader entries; decides each request.
// ----------------------------------------------------------------------------
`default_nettype none

module mbsl_datapath #(
  parameter int SLOT_COUNT  = mbsl_pkg::SLOT_COUNT_DEF,
  parameter int ENTRY_COUNT = mbsl_pkg::ENTRY_COUNT_DEF,
  parameter int MAX_READERS = mbsl_pkg::MAX_READERS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mbsl_pkg::mbsl_cmd_t            cmd,
  input  wire logic [mbsl_pkg::OP_W-1:0]      operation,
  input  wire logic [mbsl_pkg::HANDLE_W-1:0]  handle,
  output logic      [mbsl_pkg::STATUS_W-1:0]  status,
  output logic      [mbsl_pkg::GSLOT_W-1:0]   granted_slot,
  output logic      [mbsl_pkg::RENTRY_W-1:0]  reader_entry
);
  import mbsl_pkg::*;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int ENTRY_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CNT_W   = $clog2(MAX_READERS + 1);

  logic [SLOT_W-1:0]     latest_r,  latest_nxt;
  logic [SLOT_COUNT-1:0] busy_r,    busy_nxt;
  logic [CNT_W-1:0]      cnt_r     [ENTRY_COUNT];
  logic [CNT_W-1:0]      cnt_nxt   [ENTRY_COUNT];
  logic [SLOT_W-1:0]     eslot_r   [ENTRY_COUNT];
  logic [SLOT_W-1:0]     eslot_nxt [ENTRY_COUNT];

  logic [STATUS_W-1:0]   status_r,  status_nxt;
  logic [GSLOT_W-1:0]    gslot_r,   gslot_nxt;
  logic [RENTRY_W-1:0]   rentry_r,  rentry_nxt;

  // entry search
  logic                  any_hit, any_free;
  logic [ENTRY_W-1:0]    hit_idx, free_idx;
  // write slot search
  logic [SLOT_COUNT-1:0] excluded, avail;
  logic                  any_avail;
  logic [SLOT_W-1:0]     wr_idx;
  // releases
  logic                  rd_rel_ok, wr_rel_ok;
  logic [ENTRY_W-1:0]    rel_entry;
  logic [SLOT_W-1:0]     rel_slot;

  always_comb begin
    any_hit  = 1'b0;
    hit_idx  = '0;
    // walk down so the lowest matching entry wins
    for (int e = ENTRY_COUNT - 1; e >= 0; e--) begin
      if (eslot_r[e] == latest_r) begin
        any_hit = 1'b1;
        hit_idx = ENTRY_W'(e);
      end
    end
    any_free = 1'b0;
    free_idx = '0;
    // walk up so the highest free entry wins
    for (int e = 0; e < ENTRY_COUNT; e++) begin
      if (cnt_r[e] == '0) begin
        any_free = 1'b1;
        free_idx = ENTRY_W'(e);
      end
    end
  end

  always_comb begin
    excluded = busy_r;
    for (int e = 0; e < ENTRY_COUNT; e++) begin
      if (cnt_r[e] != '0) begin
        excluded = excluded | (SLOT_COUNT'(1) << eslot_r[e]);
      end
    end
    excluded  = excluded | (SLOT_COUNT'(1) << latest_r);
    avail     = ~excluded;
    any_avail = |avail;
    wr_idx    = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (avail[s]) begin
        wr_idx = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    rel_entry = handle[ENTRY_W-1:0];
    rel_slot  = SLOT_W'(handle);
    rd_rel_ok = 1'b0;
    wr_rel_ok = 1'b0;
    if (int'(handle) < ENTRY_COUNT) begin
      rd_rel_ok = (cnt_r[rel_entry] != '0);
    end
    if (int'(handle) < SLOT_COUNT) begin
      wr_rel_ok = busy_r[rel_slot];
    end
  end

  always_comb begin
    latest_nxt = latest_r;
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    eslot_nxt  = eslot_r;
    status_nxt = ST_OK;
    gslot_nxt  = '0;
    rentry_nxt = '0;
    case (op_t'(operation))
      OP_RD_ACQ: begin
        if (any_hit) begin
          if (cnt_r[hit_idx] >= CNT_W'(MAX_READERS)) begin
            status_nxt = ST_FULL;
          end else begin
            cnt_nxt[hit_idx] = cnt_r[hit_idx] + CNT_W'(1);
            gslot_nxt        = GSLOT_W'(latest_r);
            rentry_nxt       = RENTRY_W'(hit_idx);
          end
        end else if (any_free) begin
          cnt_nxt[free_idx]   = CNT_W'(1);
          eslot_nxt[free_idx] = latest_r;
          gslot_nxt           = GSLOT_W'(latest_r);
          rentry_nxt          = RENTRY_W'(free_idx);
        end else begin
          status_nxt = ST_NONE_FREE;
        end
      end
      OP_RD_REL: begin
        if (rd_rel_ok) begin
          cnt_nxt[rel_entry] = cnt_r[rel_entry] - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_HELD;
        end
      end
      OP_WR_ACQ: begin
        if (any_avail) begin
          busy_nxt[wr_idx] = 1'b1;
          gslot_nxt        = GSLOT_W'(wr_idx);
        end else begin
          status_nxt = ST_NONE_FREE;
        end
      end
      OP_WR_REL: begin
        if (wr_rel_ok) begin
          busy_nxt[rel_slot] = 1'b0;
          latest_nxt         = rel_slot;
        end else begin
          status_nxt = ST_NOT_HELD;
        end
      end
      default: begin
        status_nxt = ST_NOT_HELD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_r <= '0;
      busy_r   <= '0;
      for (int e = 0; e < ENTRY_COUNT; e++) begin
        cnt_r[e]   <= '0;
        eslot_r[e] <= '0;
      end
    end else if (cmd.load) begin
      latest_r <= latest_nxt;
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      eslot_r  <= eslot_nxt;
    end
  end

  // result word, held until the next load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= status_nxt;
      gslot_r  <= gslot_nxt;
      rentry_r <= rentry_nxt;
    end
  end

  assign status       = status_r;
  assign granted_slot = gslot_r;
  assign reader_entry = rentry_r;

endmodule

`default_nettype wire

// ===== rtl/multi_buffer_slot_lock_manager.sv =====
// ----------------------------------------------------------------------------
// multi_buffer_slot_lock_manager - reader/writer lock manager for buffer slots
// Result: the result word is valid in the cycle after its request is taken.
// Throughput: one request per cycle while result words are taken; the result register
//   lets the next request in while the current word is taken, and holds it off while not.
// Reset: synchronous rst_n clears latest slot, writer mask and all reader
//   entries at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_buffer_slot_lock_manager #(
  parameter int SLOT_COUNT  = mbsl_pkg::SLOT_COUNT_DEF,
  parameter int ENTRY_COUNT = mbsl_pkg::ENTRY_COUNT_DEF,
  parameter int MAX_READERS = mbsl_pkg::MAX_READERS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mbsl_req_if.sink   in_chan,
  mbsl_rsp_if.source out_chan
);
  import mbsl_pkg::*;

  mbsl_cmd_t cmd;

  mbsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  mbsl_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .ENTRY_COUNT (ENTRY_COUNT),
    .MAX_READERS (MAX_READERS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .operation    (in_chan.operation),
    .handle       (in_chan.handle),
    .status       (out_chan.status),
    .granted_slot (out_chan.granted_slot),
    .reader_entry (out_chan.reader_entry)
  );

endmodule

`default_nettype wire

// ===== sim/mbsl_lock_checker.sv =====
// ----------------------------------------------------------------------------
// mbsl_lock_checker - result checker for the slot lock manager
// Watches both channels, predicts each result word from its own copy of the
// latest slot, writer mask and reader table, and compares in order.
// ----------------------------------------------------------------------------
module mbsl_lock_checker (
  input  logic clk,
  input  logic rst_n,
  mbsl_req_if  req,
  mbsl_rsp_if  rsp,
  output int   fail_count,
  output int   pending,
  output int   checked_count,
  output int   refused_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbsl_pkg::*;

  localparam int SLOTS   = SLOT_COUNT_DEF;
  localparam int ENTRIES = ENTRY_COUNT_DEF;
  localparam int READERS = MAX_READERS_DEF;

  typedef struct packed {
    status_t             status;
    logic [GSLOT_W-1:0]  slot;
    logic [RENTRY_W-1:0] entry;
  } lock_result_t;

  logic [GSLOT_W-1:0] latest_slot_q;
  logic [SLOTS-1:0]   writer_busy_q;
  logic [3:0]         entry_readers_q [ENTRIES];
  logic [GSLOT_W-1:0] entry_slot_q    [ENTRIES];

  lock_result_t lock_results_due [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    refused_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_lock_state();
    latest_slot_q = '0;
    writer_busy_q = '0;
    for (int e = 0; e < ENTRIES; e++) begin
      entry_readers_q[e] = '0;
      entry_slot_q[e]    = '0;
    end
  endtask

  // Apply one request to the lock state and return the word it must produce.
  task automatic predict_lock_grant(input op_t op, input logic [HANDLE_W-1:0] handle,
                                    output lock_result_t res);
    int               free_idx;
    bit               joined;
    logic [SLOTS-1:0] blocked;
    res.status = ST_OK;
    res.slot   = '0;
    res.entry  = '0;
    case (op)
      OP_RD_ACQ: begin
        free_idx = -1;
        joined   = 1'b0;
        // match on slot alone: a free entry holding the latest slot is joined
        for (int e = 0; e < ENTRIES; e++) begin
          if (!joined) begin
            if (entry_slot_q[e] == latest_slot_q) begin
              joined = 1'b1;
              if (entry_readers_q[e] >= READERS) begin
                res.status = ST_FULL;
              end else begin
                entry_readers_q[e] = entry_readers_q[e] + 1'b1;
                res.slot  = latest_slot_q;
                res.entry = e[RENTRY_W-1:0];
              end
            end else if (entry_readers_q[e] == 0) begin
              free_idx = e;
            end
          end
        end
        if (!joined) begin
          if (free_idx < 0) begin
            res.status = ST_NONE_FREE;
          end else begin
            entry_slot_q[free_idx]    = latest_slot_q;
            entry_readers_q[free_idx] = 4'd1;
            res.slot  = latest_slot_q;
            res.entry = free_idx[RENTRY_W-1:0];
          end
        end
      end
      OP_RD_REL: begin
        if (handle >= ENTRIES) begin
          res.status = ST_NOT_HELD;
        end else if (entry_readers_q[handle] == 0) begin
          res.status = ST_NOT_HELD;
        end else begin
          entry_readers_q[handle] = entry_readers_q[handle] - 1'b1;
        end
      end
      OP_WR_ACQ: begin
        blocked = writer_busy_q;
        for (int e = 0; e < ENTRIES; e++)
          if (entry_readers_q[e] != 0) blocked[entry_slot_q[e]] = 1'b1;
        blocked[latest_slot_q] = 1'b1;
        if (&blocked) begin
          res.status = ST_NONE_FREE;
        end else begin
          joined = 1'b0;
          for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!joined && !blocked[s]) begin
              joined = 1'b1;
              writer_busy_q[s] = 1'b1;
              res.slot = s[GSLOT_W-1:0];
            end
          end
        end
      end
      default: begin
        if (handle >= SLOTS || !writer_busy_q[handle]) begin
          res.status = ST_NOT_HELD;
        end else begin
          writer_busy_q[handle] = 1'b0;
          latest_slot_q = handle;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch_channels
    lock_result_t res;
    lock_result_t due;
    if (!rst_n) begin
      clear_lock_state();
      lock_results_due.delete();
    end else begin
      if (req.valid && req.ready) begin
        predict_lock_grant(op_t'(req.operation), req.handle, res);
        lock_results_due.push_back(res);
      end
      if (rsp.valid && rsp.ready) begin
        if (lock_results_due.size() == 0) begin
          report_mismatch($sformatf(
              "result word with no request outstanding: st=%0d slot=%0d ent=%0d",
              rsp.status, rsp.granted_slot, rsp.reader_entry));
        end else begin
          due = lock_results_due.pop_front();
          checked_count++;
          if (due.status != ST_OK) refused_count++;
          if (rsp.status !== due.status || rsp.granted_slot !== due.slot ||
              rsp.reader_entry !== due.entry)
            report_mismatch($sformatf(
                "word %0d: got st=%0d slot=%0d ent=%0d, want st=%0d slot=%0d ent=%0d",
                checked_count, rsp.status, rsp.granted_slot,
                rsp.reader_entry, due.status, due.slot, due.entry));
        end
      end
    end
    pending = lock_results_due.size();
  end

endmodule

// ===== sim/tb_multi_buffer_slot_lock_manager.sv =====
// ----------------------------------------------------------------------------
// tb_multi_buffer_slot_lock_manager - testbench for the slot lock manager
// Sends a directed opening and then mostly well-formed acquire/release
// traffic built from granted handles, under four idle/stall phases; the
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_multi_buffer_slot_lock_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import mbsl_pkg::*;

  localparam int PHASE_ITEMS = 382;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;

  mbsl_req_if in_chan ();
  mbsl_rsp_if out_chan ();

  int fail_count;
  int pending;
  int checked_count;
  int refused_count;

  int send_idle_pct;
  int recv_stall_pct;
  int acquire_bias;
  int sent_count;
  int cycle_count;

  op_t ops_in_flight [$];
  int  held_entries  [$];
  int  held_slots    [$];

  multi_buffer_slot_lock_manager DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mbsl_lock_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (in_chan),
    .rsp           (out_chan),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .refused_count (refused_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still due", cycle_count, pending);
      $display("tb_multi_buffer_slot_lock_manager NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Record granted entries and slots so later releases hit held resources.
  always @(posedge clk) begin : track_grants
    op_t done_op;
    if (rst_n && out_chan.valid && out_chan.ready && ops_in_flight.size() != 0) begin
      done_op = ops_in_flight.pop_front();
      if (out_chan.status == ST_OK) begin
        if (done_op == OP_RD_ACQ) held_entries.push_back(int'(out_chan.reader_entry));
        if (done_op == OP_WR_ACQ) held_slots.push_back(int'(out_chan.granted_slot));
      end
    end
  end

  task automatic send_request(input op_t op, input logic [HANDLE_W-1:0] handle);
    if ($urandom_range(0, 99) < send_idle_pct)
      repeat ($urandom_range(1, 4)) @(negedge clk) in_chan.valid <= 1'b0;
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.handle    <= handle;
    do @(posedge clk); while (!in_chan.ready);
    ops_in_flight.push_back(op);
    sent_count++;
  endtask

  task automatic pick_random_request(output op_t op, output logic [HANDLE_W-1:0] handle);
    int idx;
    op     = OP_RD_ACQ;
    handle = HANDLE_W'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 20) begin
      // noise: any operation on any handle
      op = op_t'($urandom_range(0, 3));
    end else if ($urandom_range(0, 99) < acquire_bias ||
               (held_entries.size() == 0 && held_slots.size() == 0)) begin
      op = $urandom_range(0, 1) ? OP_WR_ACQ : OP_RD_ACQ;
    end else if (held_slots.size() == 0 ||
                 (held_entries.size() != 0 && $urandom_range(0, 1))) begin
      idx    = $urandom_range(0, held_entries.size() - 1);
      handle = HANDLE_W'(held_entries[idx]);
      held_entries.delete(idx);
      op = OP_RD_REL;
    end else begin
      idx    = $urandom_range(0, held_slots.size() - 1);
      handle = HANDLE_W'(held_slots[idx]);
      held_slots.delete(idx);
      op = OP_WR_REL;
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // swing between acquire-heavy and release-heavy stretches
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       acquire_bias = 25;
          1:       acquire_bias = 50;
          default: acquire_bias = 85;
        endcase
      end
      pick_random_request(op, handle);
      send_request(op, handle);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_RD_ACQ;
    in_chan.handle    = '0;
    out_chan.ready    = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    acquire_bias      = 50;
    sent_count        = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // releases of nothing held, including an entry index past the table
    send_request(OP_WR_REL, 3'd7);
    send_request(OP_RD_REL, 3'd0);
    send_request(OP_RD_REL, 3'd7);
    // entry 0 is free but already names slot 0, so it is joined; fill it up
    repeat (MAX_READERS_DEF) send_request(OP_RD_ACQ, 3'd0);
    send_request(OP_RD_ACQ, 3'd5);
    // publish a new slot, then a reader claims the highest free entry
    send_request(OP_WR_ACQ, 3'd0);
    send_request(OP_WR_REL, 3'd7);
    send_request(OP_RD_ACQ, 3'd0);
    send_request(OP_RD_REL, 3'd3);

    run_phase(0, 0);
    run_phase(65, 0);
    run_phase(0, 65);
    run_phase(24, 24);

    @(negedge clk) in_chan.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d lock requests over four idle/stall phases; %0d results checked.",
             sent_count, checked_count);
    $display("%0d of those were refusals (reader count full, nothing free or not held).",
             refused_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_multi_buffer_slot_lock_manager OK");
    end else begin
      $display("tb_multi_buffer_slot_lock_manager NOT OK");
    end
    $finish;
  end

endmodule
